// ===== design/rep_pkg.sv =====
// ----------------------------------------------------------------------------
// rep_pkg: shared constants and table builder for the row entropy product
// Fixed-point constants and the elaboration-time natural log table function.
// ----------------------------------------------------------------------------
`default_nettype none

package rep_pkg;

  parameter int unsigned LOG_TABLE_BITS_DEF = 10;
  parameter int unsigned MAX_ROW_LEN_DEF    = 64;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [31:0] PROD_ONE = 32'd65536;
  localparam logic [23:0] ACC_MAX  = 24'hFFFFFF;
  localparam logic [23:0] LN2_Q20  = 24'd726817;
  localparam logic [63:0] LN2_Q32  = 64'd2977044472;
  localparam int unsigned LNT_W    = 20;

  // round(ln(1 + k/2^l) * 2^20) through a 24-bit log2 by repeated squaring.
  // Only evaluated at elaboration to fill the constant table.
  function automatic logic [LNT_W-1:0] ln_mantissa(input int unsigned k,
                                                   input int unsigned l);
    logic [63:0] x;
    logic [63:0] lg;
    logic [63:0] r;
    x  = (64'd1 << 30) + (64'(k) << (30 - l));
    lg = 64'd0;
    for (int i = 0; i < 24; i++) begin
      x  = (x * x) >> 30;
      lg = lg << 1;
      if (x >= (64'd2 << 30)) begin
        lg = lg | 64'd1;
        x  = x >> 1;
      end
    end
    r = (lg * LN2_Q32 + (64'd1 << 35)) >> 36;
    return r[LNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/row_entropy_product_top.sv =====
// ----------------------------------------------------------------------------
// row_entropy_product_top: product of per-row Shannon entropies
// Streams a probability matrix, sums -p*ln(p) per row and multiplies the row
// entropies into a saturating Q16.16 product given out at each matrix end.
// ----------------------------------------------------------------------------
// Entries enter on the s_axis side one at a time; s_axis_tuser marks a row
// end and s_axis_tlast the matrix end (which also closes the row). From each
// transfer to the next ready the block runs a leading-one search with a
// registered log-table read, the -ln(p) step, then the shared 32x24
// multiplier forms p*(-ln p) and the row sum is updated. A row end adds a
// product update on the same multiplier, a matrix end a step to load the
// output register once the m_axis side no longer holds a previous result.
// The result (quality in m_axis_tdata, overflow flag in m_axis_tuser)
// waits in its output register while the next entries are processed.
`default_nettype none

module row_entropy_product_top #(
  parameter int unsigned LOG_TABLE_BITS = rep_pkg::LOG_TABLE_BITS_DEF,
  parameter int unsigned MAX_ROW_LEN    = rep_pkg::MAX_ROW_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [16:0] prob, [23:17] zero
  input  wire logic        s_axis_tuser,   // row_end
  input  wire logic        s_axis_tlast,   // matrix_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] quality
  output logic             m_axis_tuser    // overflowed
);
  import rep_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1 << LOG_TABLE_BITS;
  localparam int unsigned CNT_W       = $clog2(MAX_ROW_LEN + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOG  = 3'd1;
  localparam logic [2:0] ST_NEG  = 3'd2;
  localparam logic [2:0] ST_TMUL = 3'd3;
  localparam logic [2:0] ST_TACC = 3'd4;
  localparam logic [2:0] ST_RMUL = 3'd5;
  localparam logic [2:0] ST_RUPD = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  // constant log table
  logic [LNT_W-1:0] lnt_tab [TABLE_DEPTH];
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_lnt
    localparam logic [LNT_W-1:0] LnVal = ln_mantissa(g, LOG_TABLE_BITS);
    assign lnt_tab[g] = LnVal;
  end

  logic [2:0]       state_q, state_d;
  logic [23:0]      acc_q;
  logic [31:0]      product_q;
  logic             sat_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [31:0]      out_quality_q;
  logic             out_ovf_q;

  logic [16:0]      p_q;
  logic             rend_q, mend_q;
  logic [4:0]       b_q;
  logic [LNT_W-1:0] lnt_q;
  logic [23:0]      negln_q;
  logic [55:0]      prod_q;

  logic             in_xfer;
  logic [16:0]      prob_clamped;
  logic [4:0]       lead_pos;
  logic [4:0]       norm_sh;
  logic [16:0]      norm;
  logic [LOG_TABLE_BITS-1:0] tab_idx;
  logic [4:0]       neg_sh;
  logic [23:0]      negln_d;
  logic [31:0]      mul_a;
  logic [23:0]      mul_b;
  logic [41:0]      term_rnd;
  logic [25:0]      term;
  logic [26:0]      acc_sum;
  logic [23:0]      acc_sat;
  logic [56:0]      row_rnd;
  logic [36:0]      row_shift;
  logic             row_ovf;
  logic             row_counted;
  logic             out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_quality_q;
  assign m_axis_tuser  = out_ovf_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // values above one clamp to one, whose term is zero
  assign prob_clamped = (s_axis_tdata[16] && (|s_axis_tdata[15:0])) ? ONE_Q16
                                                                    : s_axis_tdata[16:0];

  always_comb begin
    lead_pos = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (p_q[i]) lead_pos = 5'(i);
    end
  end

  assign norm_sh = 5'd16 - lead_pos;
  assign norm    = p_q << norm_sh;
  assign tab_idx = norm[15 -: LOG_TABLE_BITS];

  assign neg_sh  = 5'd16 - b_q;
  assign negln_d = (b_q == 5'd16) ? 24'd0
                                  : (24'(neg_sh) * LN2_Q20) - {4'd0, lnt_q};

  // shared multiplier operands
  always_comb begin
    if (state_q == ST_RMUL) begin
      mul_a = product_q;
      mul_b = acc_q;
    end else begin
      mul_a = {15'd0, p_q};
      mul_b = negln_q;
    end
  end

  assign term_rnd    = prod_q[41:0] + 42'd32768;
  assign term        = term_rnd[41:16];
  assign acc_sum     = {3'd0, acc_q} + {1'b0, term};
  assign acc_sat     = (acc_sum > {3'd0, ACC_MAX}) ? ACC_MAX : acc_sum[23:0];
  assign row_counted = (cnt_q < CNT_W'(MAX_ROW_LEN));

  assign row_rnd   = {1'b0, prod_q} + 57'd524288;
  assign row_shift = row_rnd[56:20];
  assign row_ovf   = |row_shift[36:32];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_LOG;
      ST_LOG:  state_d = ST_NEG;
      ST_NEG:  state_d = ST_TMUL;
      ST_TMUL: state_d = ST_TACC;
      ST_TACC: state_d = (rend_q || mend_q) ? ST_RMUL : ST_IDLE;
      ST_RMUL: state_d = ST_RUPD;
      ST_RUPD: state_d = mend_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= 24'd0;
      product_q   <= PROD_ONE;
      sat_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new result may replace one taken in the same cycle
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_TACC: begin
          // entries past the row length limit are dropped
          if (row_counted) begin
            if (p_q != 17'd0) acc_q <= acc_sat;
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_RUPD: begin
          if (row_ovf) begin
            product_q <= 32'hFFFFFFFF;
            sat_q     <= 1'b1;
          end else begin
            product_q <= row_shift[31:0];
          end
          acc_q <= 24'd0;
          cnt_q <= '0;
        end
        ST_EMIT: begin
          if (out_free) begin
            product_q   <= PROD_ONE;
            sat_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      p_q    <= prob_clamped;
      rend_q <= s_axis_tuser;
      mend_q <= s_axis_tlast;
    end
    if (state_q == ST_LOG) begin
      b_q   <= lead_pos;
      lnt_q <= lnt_tab[tab_idx];
    end
    if (state_q == ST_NEG) negln_q <= negln_d;
    if (state_q == ST_TMUL || state_q == ST_RMUL) prod_q <= mul_a * mul_b;
    if (state_q == ST_EMIT && out_free) begin
      out_quality_q <= product_q;
      out_ovf_q     <= sat_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/rep_checker.sv =====
// ----------------------------------------------------------------------------
// rep_checker: port-level checks for the row entropy product
// Watches the stream ports of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module rep_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  import rep_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an entry keeps the block busy through the log, -ln and multiply steps
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("ready returned too early after a transfer");

  // a new result never shows up right after an entry transfer
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(m_axis_tvalid))
    else $error("result appeared right after an entry transfer");

  // a result appears only with the input side ready again
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result appeared while the sequencer was busy");

endmodule

bind row_entropy_product_top rep_checker u_rep_checker (.*);

`default_nettype wire
